// ===== sv/rde_pkg.sv =====
// Package for the raster drawing engine: opcodes, color packing, glyph font.
// No dependencies.
package rde_pkg;

	localparam int CountW = 17;
	localparam logic [CountW-1:0] CountMax = '1;

	typedef enum logic [2:0] {
		OP_PIXEL = 3'd0,
		OP_RECT  = 3'd1,
		OP_LINE  = 3'd2,
		OP_GLYPH = 3'd3,
		OP_CLEAR = 3'd4,
		OP_READ  = 3'd5
	} op_t;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [15:0] x_a;
		logic signed [15:0] y_a;
		logic signed [15:0] x_b;
		logic signed [15:0] y_b;
		logic [23:0]        color_in;
		logic [7:0]         glyph_code;
		logic [3:0]         glyph_scale;
	} cmd_t;

	typedef struct packed {
		logic [15:0]       read_data;
		logic [CountW-1:0] pixels_written;
	} rsp_t;

	function automatic logic [15:0] pack565(input logic [23:0] c);
		if (c[23:16] == 8'd0) begin
			return c[15:0];
		end
		return {c[23:19], c[15:10], c[7:3]};
	endfunction

	// One column of a 5x7 glyph; bit 0 is the top row.
	function automatic logic [6:0] glyph_col(input logic [6:0] idx, input logic [2:0] col);
		logic [39:0] r;
		case (idx)
			7'd0: r = 40'h0000000000; 7'd1: r = 40'h00005F0000;
			7'd2: r = 40'h0007000700; 7'd3: r = 40'h147F147F14;
			7'd4: r = 40'h242A7F2A12; 7'd5: r = 40'h2313086462;
			7'd6: r = 40'h3649552250; 7'd7: r = 40'h0005030000;
			7'd8: r = 40'h001C224100; 7'd9: r = 40'h0041221C00;
			7'd10: r = 40'h082A1C2A08; 7'd11: r = 40'h08083E0808;
			7'd12: r = 40'h0050300000; 7'd13: r = 40'h0808080808;
			7'd14: r = 40'h0060600000; 7'd15: r = 40'h2010080402;
			7'd16: r = 40'h3E5149453E; 7'd17: r = 40'h00427F4000;
			7'd18: r = 40'h4261514946; 7'd19: r = 40'h2141454B31;
			7'd20: r = 40'h1814127F10; 7'd21: r = 40'h2745454539;
			7'd22: r = 40'h3C4A494930; 7'd23: r = 40'h0171090503;
			7'd24: r = 40'h3649494936; 7'd25: r = 40'h064949291E;
			7'd26: r = 40'h0036360000; 7'd27: r = 40'h0056360000;
			7'd28: r = 40'h0008142241; 7'd29: r = 40'h1414141414;
			7'd30: r = 40'h4122140800; 7'd31: r = 40'h0201510906;
			7'd32: r = 40'h324979413E; 7'd33: r = 40'h7E1111117E;
			7'd34: r = 40'h7F49494936; 7'd35: r = 40'h3E41414122;
			7'd36: r = 40'h7F4141221C; 7'd37: r = 40'h7F49494941;
			7'd38: r = 40'h7F09090101; 7'd39: r = 40'h3E41415132;
			7'd40: r = 40'h7F0808087F; 7'd41: r = 40'h00417F4100;
			7'd42: r = 40'h2040413F01; 7'd43: r = 40'h7F08142241;
			7'd44: r = 40'h7F40404040; 7'd45: r = 40'h7F0204027F;
			7'd46: r = 40'h7F0408107F; 7'd47: r = 40'h3E4141413E;
			7'd48: r = 40'h7F09090906; 7'd49: r = 40'h3E4151215E;
			7'd50: r = 40'h7F09192946; 7'd51: r = 40'h4649494931;
			7'd52: r = 40'h01017F0101; 7'd53: r = 40'h3F4040403F;
			7'd54: r = 40'h1F2040201F; 7'd55: r = 40'h7F2018207F;
			7'd56: r = 40'h6314081463; 7'd57: r = 40'h0304780403;
			7'd58: r = 40'h6151494543; 7'd59: r = 40'h00007F4141;
			7'd60: r = 40'h0204081020; 7'd61: r = 40'h41417F0000;
			7'd62: r = 40'h0402010204; 7'd63: r = 40'h4040404040;
			7'd64: r = 40'h0001020400; 7'd65: r = 40'h2054545478;
			7'd66: r = 40'h7F48444438; 7'd67: r = 40'h3844444420;
			7'd68: r = 40'h384444487F; 7'd69: r = 40'h3854545418;
			7'd70: r = 40'h087E090102; 7'd71: r = 40'h081454543C;
			7'd72: r = 40'h7F08040478; 7'd73: r = 40'h00447D4000;
			7'd74: r = 40'h2040443D00; 7'd75: r = 40'h007F102844;
			7'd76: r = 40'h00417F4000; 7'd77: r = 40'h7C04180478;
			7'd78: r = 40'h7C08040478; 7'd79: r = 40'h3844444438;
			7'd80: r = 40'h7C14141408; 7'd81: r = 40'h081414187C;
			7'd82: r = 40'h7C08040408; 7'd83: r = 40'h4854545420;
			7'd84: r = 40'h043F444020; 7'd85: r = 40'h3C4040207C;
			7'd86: r = 40'h1C2040201C; 7'd87: r = 40'h3C4030403C;
			7'd88: r = 40'h4428102844; 7'd89: r = 40'h0C5050503C;
			7'd90: r = 40'h4464544C44; 7'd91: r = 40'h0008364100;
			7'd92: r = 40'h00007F0000; 7'd93: r = 40'h0041360800;
			7'd94: r = 40'h08082A1C08; 7'd95: r = 40'h081C2A0808;
			default: r = 40'h0;
		endcase
		case (col)
			3'd0: return r[38:32];
			3'd1: return r[30:24];
			3'd2: return r[22:16];
			3'd3: return r[14:8];
			default: return r[6:0];
		endcase
	endfunction

endpackage

// ===== sv/rde_if.sv =====
// Valid/ready channel interface carrying one word of type T.
// Depends on nothing; the payload type is given by the user.
interface rde_if #(parameter type T = logic) (input logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/rde_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module rde_ram #(
	parameter int Width = 16,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ===== sv/raster_draw_engine_rgb565_unit.sv =====
// Top level of the raster drawing engine: sequencer and frame store.
// Depends on rde_pkg, rde_if and rde_ram.
//
// Usage: a command word enters on cmd (valid/ready) and one response word
// leaves on rsp for every command. The engine takes one command at a time;
// cmd.ready is high only while the engine is idle and the response register
// is empty. A command is walked point by point by one sequencer that uses a
// shared address adder and clip compare, writing at most one pixel per cycle
// into a single-port frame store. A line visits every Bresenham point,
// off-screen ones included; a glyph visits each of its 5x7 dots and fills
// the clipped s*s square of every set dot; an unused op or a glyph of scale
// zero writes nothing, and an off-screen read returns zero. Throughput is
// set by the single frame store write port; a new command is taken the
// cycle after the response has been taken.
// The response waits in its register until rsp.ready; the next command is
// not taken until the response has been taken. Reset clears the sequencer and
// the response valid flag; the frame store content is not cleared and must be
// written by software before it is read.
module raster_draw_engine_rgb565_unit
	import rde_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 240
) (
	input logic clk,
	input logic arst_n,
	rde_if.sink   cmd,
	rde_if.source rsp
);
	localparam int Depth = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int AddrW = $clog2(Depth);

	// Coordinates are kept 20 bits signed: inputs plus a 15*7+16 offset fit.
	typedef logic signed [19:0] crd_t;

	typedef enum logic [3:0] {
		S_IDLE, S_BOX, S_LINE, S_GDOT, S_READ, S_READ2, S_DONE
	} state_t;

	state_t state_q;
	logic [2:0]        op_q;
	logic [15:0]       color_q;
	crd_t              x_q, y_q, xs_q, xe_q, ye_q;
	crd_t              lx_q, ly_q, lxe_q, lye_q, dx_q, dy_q, err_q;
	logic              stx_q, sty_q;
	logic [6:0]        gidx_q;
	logic [2:0]        gcol_q, grow_q;
	logic [3:0]        gscale_q;
	crd_t              gx_q, gy_q;
	logic [CountW-1:0] cnt_q;
	logic [15:0]       rd_q;
	logic              rvalid_q;
	rsp_t              rsp_q;

	// Shared write port: one address from the current point.
	crd_t       px, py;
	logic       we;
	logic       on_scr;
	logic [AddrW-1:0] addr;
	logic [15:0] rdata;
	logic [AddrW+10:0] addr_full;

	always_comb begin
		px = x_q;
		py = y_q;
		we = 1'b0;
		if (state_q == S_LINE) begin
			px = lx_q;
			py = ly_q;
		end
		on_scr = (px >= crd_t'(0)) && (px < crd_t'(SCREEN_WIDTH))
			&& (py >= crd_t'(0)) && (py < crd_t'(SCREEN_HEIGHT));
		addr_full = (AddrW+11)'(py[10:0]) * (AddrW+11)'(SCREEN_WIDTH)
			+ (AddrW+11)'(px[10:0]);
		addr = addr_full[AddrW-1:0];
		if (state_q == S_BOX) begin
			we = (x_q < xe_q) && (y_q < ye_q);
		end else if (state_q == S_LINE) begin
			we = on_scr;
		end
	end

	rde_ram #(.Width(16), .Depth(Depth)) u_store (
		.clk(clk), .we(we), .addr(addr), .wdata(color_q), .rdata(rdata)
	);

	// Glyph dot bit and square geometry.
	logic [6:0] gbits;
	logic       gdot;
	crd_t       sq_x, sq_y;
	always_comb begin
		gbits = glyph_col(gidx_q, gcol_q);
		gdot  = gbits[grow_q];
		sq_x  = gx_q + crd_t'(gcol_q) * crd_t'(gscale_q);
		sq_y  = gy_q + crd_t'(grow_q) * crd_t'(gscale_q);
	end

	function automatic crd_t cmax0(input crd_t v);
		return (v < crd_t'(0)) ? crd_t'(0) : v;
	endfunction

	crd_t cx_a, cy_a, cx_b, cy_b, e2;
	assign cx_a = crd_t'(cmd.data.x_a);
	assign cy_a = crd_t'(cmd.data.y_a);
	assign cx_b = crd_t'(cmd.data.x_b);
	assign cy_b = crd_t'(cmd.data.y_b);
	assign e2   = err_q <<< 1;

	logic [CountW-1:0] cnt_inc;
	assign cnt_inc = (cnt_q == CountMax) ? cnt_q : cnt_q + CountW'(1);

	assign cmd.ready = (state_q == S_IDLE) && !rvalid_q;
	assign rsp.valid = rvalid_q;
	assign rsp.data  = rsp_q;

	// Starts a clipped box walk; the end bounds are exclusive.
	task automatic start_box(input crd_t bx, input crd_t by, input crd_t bw,
			input crd_t bh, input state_t nxt);
		crd_t xe, ye;
		xe = (bx + bw > crd_t'(SCREEN_WIDTH)) ? crd_t'(SCREEN_WIDTH) : bx + bw;
		ye = (by + bh > crd_t'(SCREEN_HEIGHT)) ? crd_t'(SCREEN_HEIGHT) : by + bh;
		xs_q <= cmax0(bx);
		x_q  <= cmax0(bx);
		y_q  <= cmax0(by);
		xe_q <= xe;
		ye_q <= ye;
		state_q <= nxt;
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			rvalid_q <= 1'b0;
		end else begin
			if (rvalid_q && rsp.ready) begin
				rvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.valid && cmd.ready) begin
						op_q     <= cmd.data.op;
						color_q  <= pack565(cmd.data.color_in);
						cnt_q    <= '0;
						rd_q     <= '0;
						gscale_q <= cmd.data.glyph_scale;
						gx_q     <= cx_a;
						gy_q     <= cy_a;
						gcol_q   <= '0;
						grow_q   <= '0;
						gidx_q   <= (cmd.data.glyph_code < 8'd32 || cmd.data.glyph_code[7])
							? 7'd31 : 7'(cmd.data.glyph_code - 8'd32);
						case (cmd.data.op)
							OP_PIXEL: start_box(cx_a, cy_a, 20'sd1, 20'sd1, S_BOX);
							OP_RECT:  start_box(cx_a, cy_a, cx_b, cy_b, S_BOX);
							OP_CLEAR: start_box(20'sd0, 20'sd0, crd_t'(SCREEN_WIDTH),
								crd_t'(SCREEN_HEIGHT), S_BOX);
							OP_LINE: begin
								lx_q  <= cx_a;
								ly_q  <= cy_a;
								lxe_q <= cx_b;
								lye_q <= cy_b;
								dx_q  <= (cx_b > cx_a) ? cx_b - cx_a : cx_a - cx_b;
								dy_q  <= (cy_b > cy_a) ? cy_a - cy_b : cy_b - cy_a;
								err_q <= ((cx_b > cx_a) ? cx_b - cx_a : cx_a - cx_b)
									+ ((cy_b > cy_a) ? cy_a - cy_b : cy_b - cy_a);
								stx_q <= cx_a < cx_b;
								sty_q <= cy_a < cy_b;
								state_q <= S_LINE;
							end
							OP_GLYPH: state_q <= (cmd.data.glyph_scale == 4'd0) ? S_DONE : S_GDOT;
							OP_READ: begin
								x_q <= cx_a;
								y_q <= cy_a;
								state_q <= S_READ;
							end
							default:  state_q <= S_DONE;
						endcase
					end
				end
				S_BOX: begin
					if (we) begin
						cnt_q <= cnt_inc;
					end
					if ((x_q + crd_t'(1) < xe_q) && (y_q < ye_q)) begin
						x_q <= x_q + crd_t'(1);
					end else if (y_q + crd_t'(1) < ye_q && xs_q < xe_q) begin
						x_q <= xs_q;
						y_q <= y_q + crd_t'(1);
					end else if (op_q == OP_GLYPH) begin
						if (grow_q == 3'd6) begin
							grow_q  <= '0;
							gcol_q  <= gcol_q + 3'd1;
							state_q <= (gcol_q == 3'd4) ? S_DONE : S_GDOT;
						end else begin
							grow_q  <= grow_q + 3'd1;
							state_q <= S_GDOT;
						end
					end else begin
						state_q <= S_DONE;
					end
				end
				S_GDOT: begin
					if (gdot) begin
						start_box(sq_x, sq_y, crd_t'(gscale_q), crd_t'(gscale_q), S_BOX);
					end else if (grow_q == 3'd6) begin
						grow_q <= '0;
						gcol_q <= gcol_q + 3'd1;
						if (gcol_q == 3'd4) begin
							state_q <= S_DONE;
						end
					end else begin
						grow_q <= grow_q + 3'd1;
					end
				end
				S_LINE: begin
					if (we) begin
						cnt_q <= cnt_inc;
					end
					if (lx_q == lxe_q && ly_q == lye_q) begin
						state_q <= S_DONE;
					end else begin
						err_q <= err_q + ((e2 >= dy_q) ? dy_q : crd_t'(0))
							+ ((e2 <= dx_q) ? dx_q : crd_t'(0));
						if (e2 >= dy_q) begin
							lx_q <= stx_q ? lx_q + crd_t'(1) : lx_q - crd_t'(1);
						end
						if (e2 <= dx_q) begin
							ly_q <= sty_q ? ly_q + crd_t'(1) : ly_q - crd_t'(1);
						end
					end
				end
				S_READ: begin
					// Address is presented this cycle; data arrives next.
					state_q <= on_scr ? S_READ2 : S_DONE;
				end
				S_READ2: begin
					rd_q    <= rdata;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rvalid_q) begin
						rsp_q.read_data      <= rd_q;
						rsp_q.pixels_written <= cnt_q;
						rvalid_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== sv/rde_checker.sv =====
// Port-level checker for the raster drawing engine, bound to the top level.
// Depends on rde_pkg.
module rde_checker
	import rde_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_data
);
	// A word held under stall does not change.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response changed while stalled");
	// No command is taken while a response waits.
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !cmd_ready)
		else $error("command accepted with response pending");
	// A response never appears in the cycle right after a command.
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !rsp_valid)
		else $error("response too early");
	// Engine is busy right after taking a command.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("ready right after accept");
endmodule

bind raster_draw_engine_rgb565_unit rde_checker u_rde_checker (
	.clk(clk), .arst_n(arst_n),
	.cmd_valid(cmd.valid), .cmd_ready(cmd.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
